### design/sjf_pkg.sv
// Shared constants, types and the controller state encoding for the shortest-job-first block.
package sjf_pkg;

	localparam int MAX_JOBS_DEF  = 32;
	localparam int TIME_BITS_DEF = 16;

	localparam int EXEC_W   = 16;
	localparam int JOB_W    = 5;
	localparam int FINISH_W = 21;
	localparam int TOTAL_W  = 26;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	// per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctl_t;

endpackage

### design/sjf_cell.sv
// One cell of the sorted insertion chain: holds one job time and its arrival number.
module sjf_cell #(
	parameter int TW = sjf_pkg::TIME_BITS_DEF,
	parameter int IW = 5
) (
	input  logic              clk,
	input  sjf_pkg::cell_ctl_t ctl,
	input  logic              occ,
	input  logic [TW-1:0]     new_time,
	input  logic [IW-1:0]     new_id,
	input  logic              prev_take,
	input  logic [TW-1:0]     prev_time,
	input  logic [IW-1:0]     prev_id,
	input  logic [TW-1:0]     next_time,
	input  logic [IW-1:0]     next_id,
	output logic              take,
	output logic [TW-1:0]     time_q,
	output logic [IW-1:0]     id_q
);

	// strict compare keeps equal times in arrival order
	assign take = !occ || (time_q > new_time);

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			time_q <= next_time;
			id_q   <= next_id;
		end else if (ctl.insert && take) begin
			if (prev_take) begin
				time_q <= prev_time;
				id_q   <= prev_id;
			end else begin
				time_q <= new_time;
				id_q   <= new_id;
			end
		end
	end

endmodule

### design/shortest_job_first_order.sv
// Top level: insertion chain of cells, batch controller and result register.
//
// Jobs load at one beat per cycle: each accepted time is compared against every
// occupied cell at once and the cells at or past its place shift one step right,
// so the chain stays sorted (ties in arrival order). A beat with batch_end set
// stops input; the chain then shifts left one cell per cycle into the result
// register, giving one result per cycle for the N stored jobs while out_ready is
// high, after which input opens again. Jobs past MAX_JOBS are dropped and flagged
// on every result of that batch.
module shortest_job_first_order #(
	parameter int MAX_JOBS  = sjf_pkg::MAX_JOBS_DEF,
	parameter int TIME_BITS = sjf_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [sjf_pkg::EXEC_W-1:0]   exec_time,
	input  logic                         batch_end,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sjf_pkg::JOB_W-1:0]    job_number,
	output logic [sjf_pkg::FINISH_W-1:0] finish_time,
	output logic [sjf_pkg::TOTAL_W-1:0]  total_flow,
	output logic                         run_last,
	output logic                         overflowed
);

	localparam int TW = (TIME_BITS < sjf_pkg::EXEC_W) ? TIME_BITS : sjf_pkg::EXEC_W;
	localparam int IW = $clog2(MAX_JOBS);
	localparam int CW = $clog2(MAX_JOBS + 1);

	sjf_pkg::state_t   state_q, state_d;
	sjf_pkg::cell_ctl_t ctl;

	logic [CW-1:0]                count_q;
	logic                         drop_q;
	logic [sjf_pkg::FINISH_W-1:0] finish_q;
	logic [sjf_pkg::TOTAL_W-1:0]  total_q;

	logic                         in_fire, emit_go, full;
	logic [TW-1:0]                new_time;
	logic [sjf_pkg::FINISH_W-1:0] finish_nx;
	logic [sjf_pkg::TOTAL_W-1:0]  total_nx;

	logic [TW-1:0] cell_time [MAX_JOBS];
	logic [IW-1:0] cell_id   [MAX_JOBS];
	logic          cell_take [MAX_JOBS];
	logic          cell_occ  [MAX_JOBS];

	assign new_time  = exec_time[TW-1:0];
	assign full      = (count_q == CW'(MAX_JOBS));
	assign in_fire   = in_valid && in_ready;
	assign finish_nx = finish_q + sjf_pkg::FINISH_W'(cell_time[0]);
	assign total_nx  = total_q + sjf_pkg::TOTAL_W'(finish_nx);

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		emit_go    = 1'b0;
		ctl.insert = 1'b0;
		ctl.shift  = 1'b0;
		unique case (state_q)
			sjf_pkg::ST_LOAD: begin
				in_ready   = 1'b1;
				ctl.insert = in_valid && !full;
				if (in_valid && batch_end)
					state_d = sjf_pkg::ST_EMIT;
			end
			sjf_pkg::ST_EMIT: begin
				emit_go   = !out_valid || out_ready;
				ctl.shift = emit_go;
				if (emit_go && count_q == CW'(1))
					state_d = sjf_pkg::ST_LOAD;
			end
			default: state_d = sjf_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= sjf_pkg::ST_LOAD;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			drop_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_fire) begin
				if (full)
					drop_q <= 1'b1;
				else
					count_q <= count_q + CW'(1);
			end
			if (emit_go) begin
				count_q   <= count_q - CW'(1);
				out_valid <= 1'b1;
				if (count_q == CW'(1))
					drop_q <= 1'b0;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// sums restart on the closing beat; result payload needs no reset
	always_ff @(posedge clk) begin
		if (in_fire && batch_end) begin
			finish_q <= '0;
			total_q  <= '0;
		end else if (emit_go) begin
			finish_q <= finish_nx;
			total_q  <= total_nx;
		end
		if (emit_go) begin
			job_number  <= sjf_pkg::JOB_W'(cell_id[0]);
			finish_time <= finish_nx;
			total_flow  <= total_nx;
			run_last    <= (count_q == CW'(1));
			overflowed  <= drop_q;
		end
	end

	for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
		logic          p_take;
		logic [TW-1:0] p_time, n_time;
		logic [IW-1:0] p_id, n_id;

		assign cell_occ[i] = (CW'(i) < count_q);

		if (i == 0) begin : g_head
			assign p_take = 1'b0;
			assign p_time = '0;
			assign p_id   = '0;
		end else begin : g_body
			assign p_take = cell_take[i-1];
			assign p_time = cell_time[i-1];
			assign p_id   = cell_id[i-1];
		end

		if (i == MAX_JOBS - 1) begin : g_tail
			assign n_time = '0;
			assign n_id   = '0;
		end else begin : g_link
			assign n_time = cell_time[i+1];
			assign n_id   = cell_id[i+1];
		end

		sjf_cell #(
			.TW(TW),
			.IW(IW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (cell_occ[i]),
			.new_time  (new_time),
			.new_id    (count_q[IW-1:0]),
			.prev_take (p_take),
			.prev_time (p_time),
			.prev_id   (p_id),
			.next_time (n_time),
			.next_id   (n_id),
			.take      (cell_take[i]),
			.time_q    (cell_time[i]),
			.id_q      (cell_id[i])
		);
	end

endmodule
